// ----- rtl/wms_pkg.sv -----
// Shared widths, register indexes and types of the weighted moving sum.
// Used by the channel interfaces, the delay line and the top level.
`default_nettype none

package wms_pkg;

	// Default depth of the sample delay line
	localparam int MAX_WINDOW_DEF = 1024;

	// Fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 32;
	localparam int ACC_W      = 48;
	localparam int WIN_W      = 11;
	localparam int FACTOR_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register values after reset
	localparam logic [WIN_W-1:0]    WIN_RESET  = 11'd16;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE = 16'h8000;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_ALPHA         = 2'd1,
		REG_ALPHA_POW     = 2'd2
	} reg_idx_t;

	// Registered delay line output: stored sample and whether it was ever written
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] data;
		logic                       hit;
	} tap_t;

endpackage

`default_nettype wire

// ----- rtl/wms_sample_if.sv -----
// Input sample channel: valid/ready handshake carrying one Q1.15 sample.
// Depends on wms_pkg for the field width.
`default_nettype none

interface wms_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [wms_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/wms_sum_if.sv -----
// Result channel: valid/ready handshake carrying one saturated Q16.15 sum.
// Depends on wms_pkg for the field width.
`default_nettype none

interface wms_sum_if;
	logic                             valid;
	logic                             ready;
	logic signed [wms_pkg::SUM_W-1:0] sum_out;

	modport source (output valid, output sum_out, input ready);
	modport sink (input valid, input sum_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/wms_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on wms_pkg for the index and data widths.
`default_nettype none

interface wms_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wms_pkg::CFG_IDX_W-1:0]    index;
	logic [wms_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/weighted_moving_sum.sv -----
// Weighted moving sum top level: configuration registers, product pipeline, accumulator.
// Depends on wms_pkg, the three channel interfaces and wms_delay_line.
//
// One signed Q1.15 sample enters per clock while the output is not stalled, and one
// saturated Q16.15 sum leaves per sample, in order; a result passes the stage 1 and
// stage 2 registers into the output register, and a waiting output register stalls
// the input once stages 1 and 2 are full. The delay line memory is read window_length
// places back at acceptance (one read and one write port, written at acceptance, so no
// forwarding is needed); stage 1 scales the read sample by alpha_pow; stage 2 closes
// the accumulator recursion acc = sat48(rnd(acc*alpha) + sample - rnd(old*alpha_pow))
// combinationally, which holds the rate at one sample per clock. The delay line needs no
// clearing pass after reset: a fill counter makes entries not yet written read as zero.
// Write configuration only while no sample is in flight.
`default_nettype none

module weighted_moving_sum #(
	parameter int MAX_WINDOW = wms_pkg::MAX_WINDOW_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	wms_sample_if.sink   sample_ch,
	wms_sum_if.source    sum_ch,
	wms_cfg_if.sink      cfg_ch
);

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);

	// Limit a Q1.15 factor to 1.0 and widen it for signed products
	function automatic logic signed [wms_pkg::FACTOR_W:0] clamp_factor(
		input logic [wms_pkg::FACTOR_W-1:0] f
	);
		logic [wms_pkg::FACTOR_W-1:0] c;
		c = (f > wms_pkg::FACTOR_ONE) ? wms_pkg::FACTOR_ONE : f;
		return $signed({1'b0, c});
	endfunction

	logic [wms_pkg::WIN_W-1:0]    win_q;
	logic [wms_pkg::FACTOR_W-1:0] alpha_q;
	logic [wms_pkg::FACTOR_W-1:0] alpha_pow_q;

	logic [LEN_W-1:0] len_eff;
	logic             len0;
	logic             accept;
	logic             out_free, s2_free, s1_free, s1_go, s2_go;

	logic                                v_s1, len0_s1;
	logic signed [wms_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                v_s2;
	logic signed [wms_pkg::SAMPLE_W-1:0] sample_s2;
	logic signed [16:0]                  sub_s2;
	logic                                out_v_q;
	logic signed [wms_pkg::SUM_W-1:0]    sum_q;
	logic signed [wms_pkg::ACC_W-1:0]    acc_q;

	wms_pkg::tap_t tap;

	logic signed [wms_pkg::SAMPLE_W-1:0] old_s1;
	logic signed [16:0]                  ap_eff, a_eff;
	logic signed [32:0]                  prod_old;
	logic signed [33:0]                  rnd_old;
	logic signed [31:0]                  acc_hi;
	logic signed [16:0]                  acc_lo;
	logic signed [48:0]                  p_hi;
	logic signed [33:0]                  p_lo;
	logic signed [63:0]                  p_full, r_acc;
	logic signed [50:0]                  nxt;
	logic signed [wms_pkg::ACC_W-1:0]    acc_next;
	logic signed [wms_pkg::SUM_W-1:0]    sum_next;

	// Configuration writes; unknown indexes are dropped
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= wms_pkg::WIN_RESET;
			alpha_q     <= wms_pkg::FACTOR_ONE;
			alpha_pow_q <= wms_pkg::FACTOR_ONE;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				wms_pkg::REG_WINDOW_LENGTH: win_q       <= cfg_ch.data[wms_pkg::WIN_W-1:0];
				wms_pkg::REG_ALPHA:         alpha_q     <= cfg_ch.data;
				wms_pkg::REG_ALPHA_POW:     alpha_pow_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// Clamp the window to the delay line depth
	always_comb begin
		if ({21'd0, win_q} > 32'(MAX_WINDOW)) begin
			len_eff = LEN_W'(MAX_WINDOW);
		end else begin
			len_eff = LEN_W'(win_q);
		end
	end
	assign len0 = (win_q == '0);

	// Stage handshakes: each stage moves when the next one is free or moving
	assign out_free        = !out_v_q || sum_ch.ready;
	assign s2_go           = v_s2 && out_free;
	assign s2_free         = !v_s2 || out_free;
	assign s1_go           = v_s1 && s2_free;
	assign s1_free         = !v_s1 || s2_free;
	assign sample_ch.ready = s1_free;
	assign accept          = sample_ch.valid && s1_free;

	wms_delay_line #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (sample_ch.sample),
		.len     (len_eff),
		.tap     (tap)
	);

	// Stage 1: pick the leaving sample and scale it by alpha_pow
	always_comb begin
		if (len0_s1) begin
			old_s1 = sample_s1;
		end else if (tap.hit) begin
			old_s1 = $signed(tap.data);
		end else begin
			old_s1 = '0;
		end
		ap_eff   = clamp_factor(alpha_pow_q);
		prod_old = old_s1 * ap_eff;
		rnd_old  = ($signed({prod_old[32], prod_old}) + 34'sd16384) >>> 15;
	end

	// Stage 2: close the recursion with two partial products of the accumulator
	always_comb begin
		a_eff  = clamp_factor(alpha_q);
		acc_hi = acc_q[47:16];
		acc_lo = $signed({1'b0, acc_q[15:0]});
		p_hi   = acc_hi * a_eff;
		p_lo   = acc_lo * a_eff;
		p_full = (64'(p_hi) <<< 16) + 64'(p_lo);
		r_acc  = (p_full + 64'sd16384) >>> 15;
		nxt    = $signed(r_acc[50:0]) + 51'(sample_s2) - 51'(sub_s2);
		if ((&nxt[50:47]) || !(|nxt[50:47])) begin
			acc_next = nxt[47:0];
		end else if (nxt[50]) begin
			acc_next = {1'b1, {(wms_pkg::ACC_W-1){1'b0}}};
		end else begin
			acc_next = {1'b0, {(wms_pkg::ACC_W-1){1'b1}}};
		end
		if ((&acc_next[47:31]) || !(|acc_next[47:31])) begin
			sum_next = acc_next[31:0];
		end else if (acc_next[47]) begin
			sum_next = {1'b1, {(wms_pkg::SUM_W-1){1'b0}}};
		end else begin
			sum_next = {1'b0, {(wms_pkg::SUM_W-1){1'b1}}};
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_ch.sample;
			len0_s1   <= len0;
		end
		if (s1_go) begin
			sample_s2 <= sample_s1;
			sub_s2    <= rnd_old[16:0];
		end
		if (s2_go) begin
			sum_q <= sum_next;
		end
	end

	// Stage valids and the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_go) begin
				v_s2 <= 1'b1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end
			if (s2_go) begin
				out_v_q <= 1'b1;
				acc_q   <= acc_next;
			end else if (sum_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign sum_ch.valid   = out_v_q;
	assign sum_ch.sum_out = sum_q;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted transaction did not reach stage 1");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ch.ready |-> (v_s1 && v_s2 && out_v_q))
		else $error("input stalled with a free pipeline stage");

	a_s2_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go |=> out_v_q)
		else $error("stage 2 result lost before the output register");

	a_sum_tracks_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && ((&acc_q[47:31]) || !(|acc_q[47:31]))) |-> (sum_q == acc_q[31:0]))
		else $error("output sum differs from the accumulator");
`endif

endmodule

`default_nettype wire

// ----- rtl/wms_delay_line.sv -----
// Sample delay line: one-read one-write memory, write pointer and fill counter.
// Depends on wms_pkg for the sample width and the tap_t output type.
`default_nettype none

module wms_delay_line #(
	parameter int  MAX_WINDOW = wms_pkg::MAX_WINDOW_DEF,
	localparam int LEN_W      = $clog2(MAX_WINDOW + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic signed [wms_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic [LEN_W-1:0]                    len,
	output wms_pkg::tap_t                            tap
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int DW = LEN_W + 1;

	logic signed [wms_pkg::SAMPLE_W-1:0] mem [MAX_WINDOW];
	logic signed [wms_pkg::SAMPLE_W-1:0] rd_q;
	logic                                hit_q;
	logic [AW-1:0]                       wp_q;
	logic [LEN_W-1:0]                    fill_q;
	logic [DW-1:0]                       wp_x;
	logic [DW-1:0]                       len_x;
	logic [DW-1:0]                       rd_x;
	logic [AW-1:0]                       rd_addr;

	// Locate the sample len places behind the write pointer, modulo the depth
	always_comb begin
		wp_x  = {{(DW-AW){1'b0}}, wp_q};
		len_x = {1'b0, len};
		if (wp_x >= len_x) begin
			rd_x = wp_x - len_x;
		end else begin
			rd_x = wp_x + DW'(MAX_WINDOW) - len_x;
		end
		rd_addr = rd_x[AW-1:0];
	end

	// Read before write on every transaction; a full-depth window sees the old entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_q        <= mem[rd_addr];
			hit_q       <= (fill_q >= len);
			mem[wp_q]   <= wr_data;
		end
	end

	// Advance the pointer and count writes up to the depth; unwritten entries get a clear hit, read as zero on top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (wr_en) begin
			if (wp_q == AW'(MAX_WINDOW - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
			if (fill_q != LEN_W'(MAX_WINDOW)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign tap = '{data: rd_q, hit: hit_q};

endmodule

`default_nettype wire
